[src/ipv6_hlv_pkg.sv]
// Shared types, constants and helpers for the IPv6 host literal validator.
package ipv6_hlv_pkg;

  localparam int unsigned MAX_GROUPS       = 8;
  localparam int unsigned MAX_GROUP_DIGITS = 4;

  localparam logic [7:0] CH_AT       = 8'h40;
  localparam logic [7:0] CH_LBRACKET = 8'h5b;
  localparam logic [7:0] CH_RBRACKET = 8'h5d;
  localparam logic [7:0] CH_COLON    = 8'h3a;

  localparam logic [16:0] PORT_SAT = 17'd65536;
  localparam logic [16:0] PORT_MAX = 17'd65535;

  typedef enum logic [1:0] {
    VERDICT_OK          = 2'd0,
    VERDICT_INVALID     = 2'd1,
    VERDICT_USERINFO    = 2'd2,
    VERDICT_NOT_BRACKET = 2'd3
  } verdict_t;

  typedef enum logic [4:0] {
    PH_FIRST       = 5'b00001,
    PH_PLAIN       = 5'b00010,
    PH_ADDR        = 5'b00100,
    PH_PORT_START  = 5'b01000,
    PH_PORT_DIGITS = 5'b10000
  } phase_t;

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
           (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

endpackage

[src/ipv6_host_literal_validator.sv]
// Top level of the IPv6 host literal validator for HTTP Host values.
//
//   Channel   Handshake                   Payload
//   byte      byte_valid / byte_stall     ch[7:0], is_last, is_empty
//   verdict   verdict_valid / verdict_stall  verdict[1:0]
//
// One byte is taken every cycle unless the byte channel stalls; the verdict for a
// value is registered and shows in the cycle after its last byte or empty marker is taken.
// The byte channel stalls only while a verdict is held by a stalled output.
// Synchronous reset clears the parse state and the output valid.
module ipv6_host_literal_validator (
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  output logic       byte_stall,
  input  logic [7:0] ch,
  input  logic       is_last,
  input  logic       is_empty,
  output logic       verdict_valid,
  input  logic       verdict_stall,
  output logic [1:0] verdict
);

  ipv6_hlv_pkg::phase_t phase, phase_next;
  logic [2:0]  group_len, group_len_next;
  logic [3:0]  group_count, group_count_next;
  logic [1:0]  empty_groups, empty_groups_next;
  logic [1:0]  address_len, address_len_next;
  logic        leading_double_colon, leading_double_colon_next;
  logic [1:0]  recent_colons, recent_colons_next;
  logic        address_bad, address_bad_next;
  logic        userinfo_seen, userinfo_seen_next;
  logic [16:0] port_value, port_value_next;
  logic        port_has_digit, port_has_digit_next;
  logic        port_bad, port_bad_next;

  logic        accept;
  logic        finish;
  logic [1:0]  eg_closed;
  logic [2:0]  glen_inc;
  logic [20:0] port_mul;
  ipv6_hlv_pkg::verdict_t verdict_calc, verdict_next;

  assign byte_stall = verdict_valid & verdict_stall;
  assign accept     = byte_valid & ~byte_stall;
  assign finish     = accept & (is_last | is_empty);

  assign eg_closed = (group_len == 3'd0 && empty_groups != 2'd3) ?
                     empty_groups + 2'd1 : empty_groups;
  assign glen_inc  = (group_len <= 3'(ipv6_hlv_pkg::MAX_GROUP_DIGITS)) ?
                     group_len + 3'd1 : group_len;
  assign port_mul  = ({4'b0, port_value} << 3) + ({4'b0, port_value} << 1) +
                     {17'b0, ch[3:0]};

  always_comb begin
    phase_next                = phase;
    group_len_next            = group_len;
    group_count_next          = group_count;
    empty_groups_next         = empty_groups;
    address_len_next          = address_len;
    leading_double_colon_next = leading_double_colon;
    recent_colons_next        = recent_colons;
    address_bad_next          = address_bad;
    userinfo_seen_next        = userinfo_seen | (ch == ipv6_hlv_pkg::CH_AT);
    port_value_next           = port_value;
    port_has_digit_next       = port_has_digit;
    port_bad_next             = port_bad;

    unique case (phase)
      ipv6_hlv_pkg::PH_FIRST: begin
        phase_next = (ch == ipv6_hlv_pkg::CH_LBRACKET) ?
                     ipv6_hlv_pkg::PH_ADDR : ipv6_hlv_pkg::PH_PLAIN;
      end
      ipv6_hlv_pkg::PH_PLAIN: begin
      end
      ipv6_hlv_pkg::PH_ADDR: begin
        if (ch == ipv6_hlv_pkg::CH_RBRACKET) begin
          group_len_next    = 3'd0;
          empty_groups_next = eg_closed;
          phase_next        = ipv6_hlv_pkg::PH_PORT_START;
          if (address_len == 2'd0) begin
            address_bad_next = 1'b1;
          end else if (address_len == 2'd2 && recent_colons == 2'd2) begin
            address_bad_next = 1'b0;
          end else begin
            address_bad_next = address_bad ||
                (group_count >= 4'(ipv6_hlv_pkg::MAX_GROUPS)) ||
                (eg_closed == 2'd3) ||
                (eg_closed == 2'd2 && !leading_double_colon && recent_colons != 2'd2);
          end
        end else begin
          if (ch == ipv6_hlv_pkg::CH_COLON) begin
            if (address_len == 2'd1 && recent_colons == 2'd1) begin
              leading_double_colon_next = 1'b1;
            end
            group_len_next    = 3'd0;
            empty_groups_next = eg_closed;
            if (group_count != 4'd15) begin
              group_count_next = group_count + 4'd1;
            end
            if (recent_colons != 2'd2) begin
              recent_colons_next = recent_colons + 2'd1;
            end
          end else begin
            group_len_next     = glen_inc;
            recent_colons_next = 2'd0;
            if (!ipv6_hlv_pkg::is_hex(ch) ||
                glen_inc > 3'(ipv6_hlv_pkg::MAX_GROUP_DIGITS)) begin
              address_bad_next = 1'b1;
            end
          end
          if (address_len != 2'd3) begin
            address_len_next = address_len + 2'd1;
          end
        end
      end
      ipv6_hlv_pkg::PH_PORT_START, ipv6_hlv_pkg::PH_PORT_DIGITS: begin
        if (ch == ipv6_hlv_pkg::CH_RBRACKET) begin
          address_bad_next = 1'b1;
        end else if (phase == ipv6_hlv_pkg::PH_PORT_START) begin
          if (ch != ipv6_hlv_pkg::CH_COLON) begin
            port_bad_next = 1'b1;
          end
          phase_next = ipv6_hlv_pkg::PH_PORT_DIGITS;
        end else if (ipv6_hlv_pkg::is_digit(ch)) begin
          port_has_digit_next = 1'b1;
          port_value_next = (port_mul > {4'b0, ipv6_hlv_pkg::PORT_SAT}) ?
                            ipv6_hlv_pkg::PORT_SAT : port_mul[16:0];
        end else begin
          port_bad_next = 1'b1;
        end
      end
      default: begin
      end
    endcase

    priority if (userinfo_seen_next) begin
      verdict_calc = ipv6_hlv_pkg::VERDICT_USERINFO;
    end else if (phase_next == ipv6_hlv_pkg::PH_PLAIN) begin
      verdict_calc = ipv6_hlv_pkg::VERDICT_NOT_BRACKET;
    end else if (phase_next == ipv6_hlv_pkg::PH_ADDR ||
                 phase_next == ipv6_hlv_pkg::PH_FIRST || address_bad_next) begin
      verdict_calc = ipv6_hlv_pkg::VERDICT_INVALID;
    end else if (phase_next == ipv6_hlv_pkg::PH_PORT_DIGITS &&
                 (port_bad_next || !port_has_digit_next || port_value_next == 17'd0 ||
                  port_value_next > ipv6_hlv_pkg::PORT_MAX)) begin
      verdict_calc = ipv6_hlv_pkg::VERDICT_INVALID;
    end else begin
      verdict_calc = ipv6_hlv_pkg::VERDICT_OK;
    end

    verdict_next = is_empty ? ipv6_hlv_pkg::VERDICT_INVALID : verdict_calc;
  end

  always_ff @(posedge clk) begin
    if (rst || finish) begin
      phase                <= ipv6_hlv_pkg::PH_FIRST;
      group_len            <= 3'd0;
      group_count          <= 4'd0;
      empty_groups         <= 2'd0;
      address_len          <= 2'd0;
      leading_double_colon <= 1'b0;
      recent_colons        <= 2'd0;
      address_bad          <= 1'b0;
      userinfo_seen        <= 1'b0;
      port_value           <= 17'd0;
      port_has_digit       <= 1'b0;
      port_bad             <= 1'b0;
    end else if (accept) begin
      phase                <= phase_next;
      group_len            <= group_len_next;
      group_count          <= group_count_next;
      empty_groups         <= empty_groups_next;
      address_len          <= address_len_next;
      leading_double_colon <= leading_double_colon_next;
      recent_colons        <= recent_colons_next;
      address_bad          <= address_bad_next;
      userinfo_seen        <= userinfo_seen_next;
      port_value           <= port_value_next;
      port_has_digit       <= port_has_digit_next;
      port_bad             <= port_bad_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      verdict_valid <= 1'b0;
    end else if (finish) begin
      verdict_valid <= 1'b1;
    end else if (!verdict_stall) begin
      verdict_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      verdict <= verdict_next;
    end
  end

`ifndef SYNTHESIS
  a_reset_clears_output: assert property (@(posedge clk) rst |=> !verdict_valid)
    else $error("Verdict valid is set right after reset.");

  a_empty_gives_invalid: assert property (@(posedge clk) disable iff (rst)
    accept && is_empty |=> verdict_valid &&
      verdict == ipv6_hlv_pkg::VERDICT_INVALID)
    else $error("An empty value did not give the invalid verdict.");

  a_finish_resets_phase: assert property (@(posedge clk) disable iff (rst)
    finish |=> phase == ipv6_hlv_pkg::PH_FIRST)
    else $error("Parse state was not returned to the first byte after a verdict.");

  a_verdict_only_on_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(verdict_valid) |-> $past(finish))
    else $error("A verdict appeared without a final byte transaction.");

  a_mid_byte_no_verdict: assert property (@(posedge clk) disable iff (rst)
    accept && !is_last && !is_empty |=>
      verdict_valid == $past(verdict_valid && verdict_stall))
    else $error("A byte that is not the last one changed the verdict output.");
`endif

endmodule

[bench/tb.sv]
// Self-checking testbench for the IPv6 host literal validator.
`timescale 1ns / 100ps

module tb;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int BYTE_TARGET  = 1760;
  localparam int HOLD_CYCLES  = 300;
  localparam int DIR_ROWS     = 25;

  typedef struct packed {
    logic [7:0]             ch;
    logic                   last;
    logic                   empty;
    logic                   typed;
    ipv6_hlv_pkg::verdict_t verdict;
  } byte_txn_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       byte_valid = 1'b0;
  logic       byte_stall;
  logic [7:0] ch = 8'h00;
  logic       is_last = 1'b0;
  logic       is_empty = 1'b0;
  logic       verdict_valid;
  logic       verdict_stall = 1'b0;
  logic [1:0] verdict;

  ipv6_host_literal_validator dut (
    .clk           (clk),
    .rst           (rst),
    .byte_valid    (byte_valid),
    .byte_stall    (byte_stall),
    .ch            (ch),
    .is_last       (is_last),
    .is_empty      (is_empty),
    .verdict_valid (verdict_valid),
    .verdict_stall (verdict_stall),
    .verdict       (verdict)
  );

  always #5 clk = ~clk;

  // Parse state of the host value as the block should track it.
  ipv6_hlv_pkg::phase_t ph;
  logic [2:0]  grp_len;
  logic [3:0]  grp_cnt;
  logic [1:0]  empty_grps;
  logic [1:0]  addr_len;
  logic        lead_dc;
  logic [1:0]  colon_run;
  logic        addr_bad;
  logic        at_seen;
  logic [16:0] port_val;
  logic        port_digit;
  logic        port_bad;

  ipv6_hlv_pkg::verdict_t expected_verdicts[$];
  ipv6_hlv_pkg::verdict_t want;
  logic [7:0]  value_bytes[$];
  string       hex_set = "0123456789abcdefABCDEF";
  int          bad_verdicts = 0;
  int          bytes_sent = 0;
  int          send_calm = 0;
  bit          hold_request = 1'b0;

  string dir_text [DIR_ROWS] = '{
    "", "[1:", "@", "[::1]@x", "example.com", "\377", "[", "[]", "[::]",
    "[::1]:80", "[fe80::]:65535", "[1:2:3:4:5:6:7:8]", "[1:2:3:4:5:6:7:8:9]",
    "[abcd:EF01:12345::]", "[1::2::3]", "[:::]",
    "[::]]", "[::]x", "[::]:", "[::]:0", "[::]:65536", "[::]:99999999", "[::]:8a",
    "[g::]", "[::1]:1"
  };
  bit dir_abort [DIR_ROWS] = '{
    1, 1, 0, 0, 0, 0, 0, 0, 0,
    0, 0, 0, 0, 0, 0, 0,
    0, 0, 0, 0, 0, 0, 0,
    0, 0
  };
  bit dir_typed [DIR_ROWS] = '{
    1, 1, 1, 1, 1, 1, 1, 1, 1,
    0, 0, 0, 0, 0, 0, 0,
    1, 1, 1, 1, 1, 1, 1,
    0, 0
  };
  ipv6_hlv_pkg::verdict_t dir_verdict [DIR_ROWS] = '{
    ipv6_hlv_pkg::VERDICT_INVALID, ipv6_hlv_pkg::VERDICT_INVALID,
    ipv6_hlv_pkg::VERDICT_USERINFO, ipv6_hlv_pkg::VERDICT_USERINFO,
    ipv6_hlv_pkg::VERDICT_NOT_BRACKET, ipv6_hlv_pkg::VERDICT_NOT_BRACKET,
    ipv6_hlv_pkg::VERDICT_INVALID, ipv6_hlv_pkg::VERDICT_INVALID,
    ipv6_hlv_pkg::VERDICT_OK,
    ipv6_hlv_pkg::VERDICT_OK, ipv6_hlv_pkg::VERDICT_OK, ipv6_hlv_pkg::VERDICT_OK,
    ipv6_hlv_pkg::VERDICT_OK, ipv6_hlv_pkg::VERDICT_OK, ipv6_hlv_pkg::VERDICT_OK,
    ipv6_hlv_pkg::VERDICT_OK,
    ipv6_hlv_pkg::VERDICT_INVALID, ipv6_hlv_pkg::VERDICT_INVALID,
    ipv6_hlv_pkg::VERDICT_INVALID, ipv6_hlv_pkg::VERDICT_INVALID,
    ipv6_hlv_pkg::VERDICT_INVALID, ipv6_hlv_pkg::VERDICT_INVALID,
    ipv6_hlv_pkg::VERDICT_INVALID,
    ipv6_hlv_pkg::VERDICT_OK, ipv6_hlv_pkg::VERDICT_OK
  };

  function automatic bit hex_char(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic void clear_parse();
    ph         = ipv6_hlv_pkg::PH_FIRST;
    grp_len    = '0;
    grp_cnt    = '0;
    empty_grps = '0;
    addr_len   = '0;
    lead_dc    = 1'b0;
    colon_run  = '0;
    addr_bad   = 1'b0;
    at_seen    = 1'b0;
    port_val   = '0;
    port_digit = 1'b0;
    port_bad   = 1'b0;
  endfunction

  function automatic void end_group();
    if (grp_len == 0 && empty_grps < 3) empty_grps++;
    grp_len = '0;
  endfunction

  // Advances the parse by one byte and reports whether a verdict is due.
  function automatic bit predict_verdict(input logic [7:0] c, input logic last,
                                         input logic empty,
                                         output ipv6_hlv_pkg::verdict_t v);
    int unsigned next_port;
    v = ipv6_hlv_pkg::VERDICT_OK;
    if (empty) begin
      v = ipv6_hlv_pkg::VERDICT_INVALID;
      clear_parse();
      return 1'b1;
    end
    if (c == ipv6_hlv_pkg::CH_AT) at_seen = 1'b1;
    case (ph)
      ipv6_hlv_pkg::PH_FIRST: begin
        ph = (c == ipv6_hlv_pkg::CH_LBRACKET) ? ipv6_hlv_pkg::PH_ADDR
                                              : ipv6_hlv_pkg::PH_PLAIN;
      end
      ipv6_hlv_pkg::PH_ADDR: begin
        if (c == ipv6_hlv_pkg::CH_RBRACKET) begin
          end_group();
          if (addr_len == 0) begin
            addr_bad = 1'b1;
          end else if (addr_len == 2 && colon_run == 2) begin
            addr_bad = 1'b0;
          end else begin
            addr_bad = addr_bad || (grp_cnt + 1 > ipv6_hlv_pkg::MAX_GROUPS) ||
                       empty_grps == 3 ||
                       (empty_grps == 2 && !lead_dc && colon_run < 2);
          end
          ph = ipv6_hlv_pkg::PH_PORT_START;
        end else begin
          if (c == ipv6_hlv_pkg::CH_COLON) begin
            if (addr_len == 1 && colon_run == 1) lead_dc = 1'b1;
            end_group();
            if (grp_cnt < 15) grp_cnt++;
            if (colon_run < 2) colon_run++;
          end else begin
            if (!hex_char(c)) addr_bad = 1'b1;
            if (grp_len <= ipv6_hlv_pkg::MAX_GROUP_DIGITS) grp_len++;
            if (grp_len > ipv6_hlv_pkg::MAX_GROUP_DIGITS) addr_bad = 1'b1;
            colon_run = '0;
          end
          if (addr_len < 3) addr_len++;
        end
      end
      ipv6_hlv_pkg::PH_PORT_START, ipv6_hlv_pkg::PH_PORT_DIGITS: begin
        if (c == ipv6_hlv_pkg::CH_RBRACKET) begin
          addr_bad = 1'b1;
        end else if (ph == ipv6_hlv_pkg::PH_PORT_START) begin
          if (c != ipv6_hlv_pkg::CH_COLON) port_bad = 1'b1;
          ph = ipv6_hlv_pkg::PH_PORT_DIGITS;
        end else if (c >= "0" && c <= "9") begin
          port_digit = 1'b1;
          next_port = port_val * 10 + (c - "0");
          port_val = (next_port > ipv6_hlv_pkg::PORT_SAT) ? ipv6_hlv_pkg::PORT_SAT
                                                          : next_port[16:0];
        end else begin
          port_bad = 1'b1;
        end
      end
      default: ;
    endcase
    if (!last) return 1'b0;
    if (at_seen) begin
      v = ipv6_hlv_pkg::VERDICT_USERINFO;
    end else if (ph == ipv6_hlv_pkg::PH_PLAIN) begin
      v = ipv6_hlv_pkg::VERDICT_NOT_BRACKET;
    end else if (ph == ipv6_hlv_pkg::PH_ADDR || ph == ipv6_hlv_pkg::PH_FIRST || addr_bad) begin
      v = ipv6_hlv_pkg::VERDICT_INVALID;
    end else if (ph == ipv6_hlv_pkg::PH_PORT_DIGITS &&
                 (port_bad || !port_digit || port_val == 0 ||
                  port_val > ipv6_hlv_pkg::PORT_MAX)) begin
      v = ipv6_hlv_pkg::VERDICT_INVALID;
    end
    clear_parse();
    return 1'b1;
  endfunction

  function automatic int sender_gap();
    int r;
    if (send_calm > 0) begin
      send_calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      send_calm = $urandom_range(30, 120);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic logic [7:0] noise_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return 8'h00;
    if (r < 10) return 8'hff;
    if (r < 14) return ipv6_hlv_pkg::CH_AT;
    if (r < 22) return ipv6_hlv_pkg::CH_RBRACKET;
    if (r < 32) return ipv6_hlv_pkg::CH_COLON;
    if (r < 38) return ipv6_hlv_pkg::CH_LBRACKET;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic void append_byte(input logic [7:0] c);
    value_bytes = {value_bytes, c};
  endfunction

  function automatic void push_text(input string s);
    for (int j = 0; j < s.len(); j++) append_byte(s[j]);
  endfunction

  function automatic void add_groups(input int n);
    int r;
    int digits;
    for (int i = 0; i < n; i++) begin
      if (i > 0) append_byte(ipv6_hlv_pkg::CH_COLON);
      r = $urandom_range(0, 99);
      digits = (r < 92) ? $urandom_range(1, 4) : ((r < 96) ? 0 : 5);
      for (int j = 0; j < digits; j++) append_byte(hex_set[$urandom_range(0, 21)]);
    end
  endfunction

  // Builds a bracketed address with an optional port; most come out well formed.
  function automatic void build_address();
    int r;
    append_byte(ipv6_hlv_pkg::CH_LBRACKET);
    case ($urandom_range(0, 5))
      0: add_groups(($urandom_range(0, 9) == 0) ? 9 : $urandom_range(1, 8));
      1: begin
        push_text("::");
        add_groups($urandom_range(0, 7));
      end
      2: begin
        add_groups($urandom_range(1, 7));
        push_text("::");
      end
      3: begin
        add_groups($urandom_range(1, 3));
        push_text("::");
        add_groups($urandom_range(1, 4));
      end
      4: push_text("::");
      default: begin
        add_groups($urandom_range(1, 3));
        push_text("::");
        add_groups($urandom_range(1, 2));
        push_text("::");
        add_groups($urandom_range(0, 2));
      end
    endcase
    append_byte(ipv6_hlv_pkg::CH_RBRACKET);
    r = $urandom_range(0, 99);
    if (r < 35) begin
    end else if (r < 78) begin
      push_text($sformatf(":%0d", $urandom_range(1, 65535)));
    end else if (r < 84) begin
      push_text(($urandom_range(0, 1) == 1) ? ":1" : ":65535");
    end else begin
      case ($urandom_range(0, 5))
        0: push_text(":");
        1: push_text(":0");
        2: push_text(":65536");
        3: push_text($sformatf(":%0d", $urandom_range(65537, 99999999)));
        4: begin
          push_text($sformatf(":%0d", $urandom_range(1, 999)));
          append_byte(noise_byte());
        end
        default: append_byte(noise_byte());
      endcase
    end
  endfunction

  task automatic send_byte(input byte_txn_t t);
    int gap;
    ipv6_hlv_pkg::verdict_t v;
    gap = sender_gap();
    if (gap > 0) begin
      byte_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_valid <= 1'b1;
    ch         <= t.ch;
    is_last    <= t.last;
    is_empty   <= t.empty;
    @(posedge clk);
    while (byte_stall) @(posedge clk);
    if (predict_verdict(t.ch, t.last, t.empty, v)) begin
      if (t.typed) v = t.verdict;
      expected_verdicts = {expected_verdicts, v};
    end
    bytes_sent++;
  endtask

  task automatic send_value(input bit abort, input bit typed,
                            input ipv6_hlv_pkg::verdict_t v);
    byte_txn_t t;
    int n;
    n = value_bytes.size();
    for (int i = 0; i < n; i++) begin
      t.ch      = value_bytes[i];
      t.last    = !abort && i == n - 1;
      t.empty   = 1'b0;
      t.typed   = typed && t.last;
      t.verdict = v;
      send_byte(t);
    end
    if (abort) begin
      t.ch      = 8'($urandom_range(0, 255));
      t.last    = 1'($urandom_range(0, 1));
      t.empty   = 1'b1;
      t.typed   = typed;
      t.verdict = v;
      send_byte(t);
    end
  endtask

  task automatic wait_drained();
    byte_valid <= 1'b0;
    do @(posedge clk); while (expected_verdicts.size() != 0);
  endtask

  // The receiver stalls at random and now and then holds off for a long stretch.
  initial begin
    int stall_left;
    int calm;
    int hold_left;
    int r;
    stall_left = 0;
    calm = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        verdict_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        verdict_stall <= 1'b1;
      end else if (calm > 0) begin
        calm--;
        verdict_stall <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 4) begin
          calm = $urandom_range(30, 100);
          verdict_stall <= 1'b0;
        end else if (r < 70) begin
          verdict_stall <= 1'b0;
        end else if (r < 94) begin
          stall_left = $urandom_range(0, 2);
          verdict_stall <= 1'b1;
        end else begin
          stall_left = $urandom_range(5, 40);
          verdict_stall <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && verdict_valid && !verdict_stall) begin
      if (expected_verdicts.size() == 0) begin
        bad_verdicts++;
        if (bad_verdicts <= 10) $display("Unexpected verdict %0d with none pending.", verdict);
      end else begin
        want = expected_verdicts.pop_front();
        if (verdict !== want) begin
          bad_verdicts++;
          if (bad_verdicts <= 10)
            $display("Verdict mismatch: expected %0d, got %0d.", want, verdict);
        end
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("tb NOT OK");
    $finish;
  end

  initial begin
    int r;
    int k;
    int value_count;
    bit abort;
    clear_parse();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_ROWS; i++) begin
      value_bytes.delete();
      push_text(dir_text[i]);
      send_value(dir_abort[i], dir_typed[i], dir_verdict[i]);
    end

    value_count = 0;
    while (bytes_sent < BYTE_TARGET) begin
      value_count++;
      if (value_count == 20) hold_request = 1'b1;
      if (value_count == 45) wait_drained();
      value_bytes.delete();
      abort = 1'b0;
      r = $urandom_range(0, 99);
      if (r < 55) begin
        build_address();
      end else if (r < 65) begin
        build_address();
        value_bytes[$urandom_range(0, value_bytes.size() - 1)] = noise_byte();
      end else if (r < 76) begin
        append_byte(ipv6_hlv_pkg::CH_LBRACKET);
        k = $urandom_range(0, 12);
        for (int j = 0; j < k; j++)
          append_byte(($urandom_range(0, 1) == 1) ? hex_set[$urandom_range(0, 21)]
                                                  : noise_byte());
      end else if (r < 86) begin
        k = $urandom_range(1, 8);
        for (int j = 0; j < k; j++) append_byte(noise_byte());
        if (value_bytes[0] == ipv6_hlv_pkg::CH_LBRACKET)
          value_bytes[0] = hex_set[$urandom_range(0, 21)];
      end else if (r < 93) begin
        build_address();
        k = $urandom_range(1, value_bytes.size());
        while (value_bytes.size() > k) void'(value_bytes.pop_back());
      end else begin
        build_address();
        k = $urandom_range(0, value_bytes.size());
        while (value_bytes.size() > k) void'(value_bytes.pop_back());
        abort = 1'b1;
      end
      send_value(abort, 1'b0, ipv6_hlv_pkg::VERDICT_OK);
    end

    byte_valid <= 1'b0;
    wait_drained();
    repeat (5) @(posedge clk);
    if (bad_verdicts == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
